// ----- hw/rtl/conjugate_gradient_direction_top_assert.svh -----
// Assertion macros for the conjugate gradient direction block.
// Included by conjugate_gradient_direction_top for its assertions; no dependencies.
`ifndef CONJUGATE_GRADIENT_DIRECTION_TOP_ASSERT_SVH
`define CONJUGATE_GRADIENT_DIRECTION_TOP_ASSERT_SVH

`ifndef SYNTH
`define CGD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cgd assertion failed");
`define CGD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cgd assertion failed");
`else
`define CGD_ASSERT_IMP(name, clk, rst, ante, cons)
`define CGD_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/cgd_pkg.sv -----
// Shared widths, codes and types for the conjugate gradient direction block.
// Used by cgd_div, conjugate_gradient_direction_top and the sim files; depends on nothing.
package cgd_pkg;

   localparam int GRAD_WIDTH    = 24;
   localparam int INDEX_WIDTH   = 12;
   // The depth is a power of two no larger than the index range.
   localparam int VECTOR_DEPTH  = 4096;
   localparam int ADDR_WIDTH    = $clog2(VECTOR_DEPTH);
   localparam int ACC_WIDTH     = 60;
   localparam int DEN_WIDTH     = ACC_WIDTH - 1;
   localparam int BETA_WIDTH    = 32;
   localparam int FRAC_BITS     = 16;
   localparam int BETA_INT_BITS = BETA_WIDTH - FRAC_BITS;
   localparam int CNT_WIDTH     = $clog2(BETA_WIDTH);
   localparam int PROD_WIDTH    = 2 * GRAD_WIDTH;
   localparam int SCALE_WIDTH   = GRAD_WIDTH + BETA_WIDTH;
   localparam int LIM_WIDTH     = GRAD_WIDTH + FRAC_BITS + 1;
   localparam int TERM_WIDTH    = LIM_WIDTH + 1;
   localparam int SUM_WIDTH     = GRAD_WIDTH + FRAC_BITS + 3;
   localparam int RES_WIDTH     = SUM_WIDTH - FRAC_BITS;

   typedef enum logic {
      FUNC_CORR   = 1'b0,
      FUNC_UPDATE = 1'b1
   } func_type;

   typedef enum logic {
      KIND_BETA      = 1'b0,
      KIND_DIRECTION = 1'b1
   } kind_type;

   typedef logic [ACC_WIDTH-1:0] acc_type;

endpackage

// ----- hw/rtl/cgd_div.sv -----
// Restoring divider that forms the unsigned Q16.16 beta quotient, one bit per cycle.
// Depends on cgd_pkg.
module cgd_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  cgd_pkg::acc_type                 numer,
   input  logic [cgd_pkg::DEN_WIDTH-1:0]    denom,
   output logic                             done,
   output logic [cgd_pkg::BETA_WIDTH-1:0]   quot
);

   logic                             busy_ff;
   logic                             done_ff;
   logic [cgd_pkg::CNT_WIDTH-1:0]    count_ff;
   logic [cgd_pkg::DEN_WIDTH-1:0]    rem_ff;
   logic [cgd_pkg::DEN_WIDTH-1:0]    rem_in;
   logic [cgd_pkg::DEN_WIDTH-1:0]    den_ff;
   logic [cgd_pkg::BETA_WIDTH-1:0]   low_ff;
   logic [cgd_pkg::BETA_WIDTH-1:0]   quot_ff;
   logic [cgd_pkg::DEN_WIDTH:0]      trial;
   logic [cgd_pkg::DEN_WIDTH:0]      diff;
   logic                             take;
   logic                             overflow;

   // The quotient exceeds the Q16.16 range exactly when the integer part of
   // numer / 2^16 already reaches the divisor.
   assign overflow = cgd_pkg::DEN_WIDTH'(numer[cgd_pkg::ACC_WIDTH-1:cgd_pkg::BETA_INT_BITS])
                     >= denom;

   always_comb begin
      trial  = {rem_ff, low_ff[cgd_pkg::BETA_WIDTH-1]};
      diff   = trial - {1'b0, den_ff};
      take   = trial >= {1'b0, den_ff};
      rem_in = take ? diff[cgd_pkg::DEN_WIDTH-1:0] : trial[cgd_pkg::DEN_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= !overflow;
            done_ff <= overflow;
         end else if (busy_ff && (count_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= cgd_pkg::DEN_WIDTH'(numer[cgd_pkg::ACC_WIDTH-1:cgd_pkg::BETA_INT_BITS]);
         low_ff   <= {numer[cgd_pkg::BETA_INT_BITS-1:0], {cgd_pkg::FRAC_BITS{1'b0}}};
         den_ff   <= denom;
         count_ff <= cgd_pkg::CNT_WIDTH'(cgd_pkg::BETA_WIDTH - 1);
         quot_ff  <= overflow ? '1 : '0;
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         low_ff   <= {low_ff[cgd_pkg::BETA_WIDTH-2:0], 1'b0};
         count_ff <= count_ff - 1'b1;
         quot_ff  <= {quot_ff[cgd_pkg::BETA_WIDTH-2:0], take};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- hw/rtl/conjugate_gradient_direction_top.sv -----
// Every item passes S_MUL, S_ADD and S_FIN; the block takes a new item only in S_IDLE.
// An update item then emits its direction from S_EMIT. A correlation item that is not
// last returns to S_IDLE with no result; the last one emits beta, after the 32-step beta
// divider has run in S_DIV when a division is needed. A quotient past the Q16.16 range
// ends the division at once. A stalled result holds the block in its emit state. Synchronous
// reset clears the sums, beta and control state and sets restart to 1, not the memories.
module conjugate_gradient_direction_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [cgd_pkg::INDEX_WIDTH-1:0]        req_index,
   input  logic signed [cgd_pkg::GRAD_WIDTH-1:0]  req_grad,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_kind,
   output logic [cgd_pkg::INDEX_WIDTH-1:0]        rsp_out_index,
   output logic signed [cgd_pkg::GRAD_WIDTH-1:0]  rsp_direction,
   output logic [cgd_pkg::BETA_WIDTH-1:0]         rsp_beta,
   output logic                                   rsp_out_last,
   input  logic                                   csr_we,
   input  logic                                   csr_wdata
);

`include "conjugate_gradient_direction_top_assert.svh"

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_ADD  = 6'b000100,
      S_FIN  = 6'b001000,
      S_DIV  = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   state_type                                state_ff, state_in;
   logic                                     restart_ff;

   cgd_pkg::func_type                        func_ff;
   logic                                     last_ff;
   logic [cgd_pkg::INDEX_WIDTH-1:0]          index_ff;
   logic signed [cgd_pkg::GRAD_WIDTH-1:0]    grad_ff;

   logic signed [cgd_pkg::GRAD_WIDTH-1:0]    prev_mem [cgd_pkg::VECTOR_DEPTH];
   logic signed [cgd_pkg::GRAD_WIDTH-1:0]    dir_mem  [cgd_pkg::VECTOR_DEPTH];
   logic signed [cgd_pkg::GRAD_WIDTH-1:0]    prev_rd_ff;
   logic signed [cgd_pkg::GRAD_WIDTH-1:0]    dir_rd_ff;

   logic signed [cgd_pkg::PROD_WIDTH-1:0]    gg_ff, gp_ff, pp_ff;
   logic [cgd_pkg::SCALE_WIDTH-1:0]          pm_ff, pm_in;
   logic                                     dneg_ff;
   logic [cgd_pkg::TERM_WIDTH-1:0]           prod_ff, prod_in;

   cgd_pkg::acc_type                         sgs_ff, sgs_in;
   cgd_pkg::acc_type                         scr_ff, scr_in;
   cgd_pkg::acc_type                         spq_ff, spq_in;
   logic [cgd_pkg::BETA_WIDTH-1:0]           beta_ff, beta_in;
   logic [cgd_pkg::GRAD_WIDTH-1:0]           res_dir_ff, res_dir_in;

   logic                                     rsp_valid_ff;
   cgd_pkg::kind_type                        rsp_kind_ff;
   logic [cgd_pkg::INDEX_WIDTH-1:0]          rsp_index_ff;
   logic [cgd_pkg::GRAD_WIDTH-1:0]           rsp_dir_ff;
   logic [cgd_pkg::BETA_WIDTH-1:0]           rsp_beta_ff;
   logic                                     rsp_last_ff;

   logic                                     accept;
   logic                                     out_free;
   logic                                     mem_we;
   logic [cgd_pkg::ADDR_WIDTH-1:0]           addr_rd, addr_wr;
   logic [cgd_pkg::GRAD_WIDTH-1:0]           dmag;
   logic [cgd_pkg::SCALE_WIDTH-1:0]          lim;
   logic [cgd_pkg::LIM_WIDTH-1:0]            pm_sat;
   logic [cgd_pkg::TERM_WIDTH-1:0]           term_pos;
   logic [cgd_pkg::SUM_WIDTH-1:0]            sum;
   logic [cgd_pkg::RES_WIDTH-1:0]            res;
   logic                                     pos_ovf, neg_ovf;
   logic [cgd_pkg::GRAD_WIDTH-1:0]           dir_calc, dir_new;
   logic [cgd_pkg::ACC_WIDTH:0]              num;
   logic                                     num_pos, den_pos;
   logic                                     fin_corr_last;
   logic                                     div_start, div_done;
   logic [cgd_pkg::BETA_WIDTH-1:0]           div_quot;
   logic                                     beta_shown;
   logic                                     corr_mid_fin;

   // Adds a product to a sum and saturates to the signed accumulator range.
   function automatic cgd_pkg::acc_type acc_add(input cgd_pkg::acc_type acc,
                                                input logic [cgd_pkg::PROD_WIDTH-1:0] p);
      logic [cgd_pkg::ACC_WIDTH:0] s;
      s = {acc[cgd_pkg::ACC_WIDTH-1], acc}
          + {{(cgd_pkg::ACC_WIDTH + 1 - cgd_pkg::PROD_WIDTH){p[cgd_pkg::PROD_WIDTH-1]}}, p};
      if (s[cgd_pkg::ACC_WIDTH] != s[cgd_pkg::ACC_WIDTH-1]) begin
         acc_add = s[cgd_pkg::ACC_WIDTH] ? {1'b1, {(cgd_pkg::ACC_WIDTH-1){1'b0}}}
                                         : {1'b0, {(cgd_pkg::ACC_WIDTH-1){1'b1}}};
      end else begin
         acc_add = s[cgd_pkg::ACC_WIDTH-1:0];
      end
   endfunction

   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign addr_rd   = req_index[cgd_pkg::ADDR_WIDTH-1:0];
   assign addr_wr   = index_ff[cgd_pkg::ADDR_WIDTH-1:0];
   assign mem_we    = (state_ff == S_FIN) && (func_ff == cgd_pkg::FUNC_UPDATE);

   // beta * d_old as sign and magnitude, clamped at 2^(GRAD_WIDTH+16).
   always_comb begin
      dmag     = dir_rd_ff[cgd_pkg::GRAD_WIDTH-1] ? unsigned'(-dir_rd_ff)
                                                 : unsigned'(dir_rd_ff);
      pm_in    = cgd_pkg::SCALE_WIDTH'(dmag) * cgd_pkg::SCALE_WIDTH'(beta_ff);
      lim      = {{(cgd_pkg::SCALE_WIDTH-cgd_pkg::LIM_WIDTH){1'b0}}, 1'b1,
                  {(cgd_pkg::LIM_WIDTH-1){1'b0}}};
      pm_sat   = (pm_ff > lim) ? lim[cgd_pkg::LIM_WIDTH-1:0]
                               : pm_ff[cgd_pkg::LIM_WIDTH-1:0];
      term_pos = {1'b0, pm_sat};
      prod_in  = dneg_ff ? (~term_pos + 1'b1) : term_pos;
   end

   // g * 2^16 + product, rounded half up and floored back to Q8.16.
   always_comb begin
      sum = {{(cgd_pkg::SUM_WIDTH-cgd_pkg::GRAD_WIDTH-cgd_pkg::FRAC_BITS)
               {grad_ff[cgd_pkg::GRAD_WIDTH-1]}},
             grad_ff, {cgd_pkg::FRAC_BITS{1'b0}}}
          + {{(cgd_pkg::SUM_WIDTH-cgd_pkg::TERM_WIDTH){prod_ff[cgd_pkg::TERM_WIDTH-1]}},
             prod_ff}
          + {{(cgd_pkg::SUM_WIDTH-cgd_pkg::FRAC_BITS){1'b0}}, 1'b1,
             {(cgd_pkg::FRAC_BITS-1){1'b0}}};
      res     = sum[cgd_pkg::SUM_WIDTH-1:cgd_pkg::FRAC_BITS];
      pos_ovf = !res[cgd_pkg::RES_WIDTH-1]
                && (res[cgd_pkg::RES_WIDTH-2:cgd_pkg::GRAD_WIDTH-1] != '0);
      neg_ovf = res[cgd_pkg::RES_WIDTH-1]
                && (res[cgd_pkg::RES_WIDTH-2:cgd_pkg::GRAD_WIDTH-1] != '1);
      if (pos_ovf) begin
         dir_calc = {1'b0, {(cgd_pkg::GRAD_WIDTH-1){1'b1}}};
      end else if (neg_ovf) begin
         dir_calc = {1'b1, {(cgd_pkg::GRAD_WIDTH-1){1'b0}}};
      end else begin
         dir_calc = res[cgd_pkg::GRAD_WIDTH-1:0];
      end
      dir_new = restart_ff ? grad_ff : dir_calc;
   end

   always_comb begin
      num = {sgs_ff[cgd_pkg::ACC_WIDTH-1], sgs_ff} - {scr_ff[cgd_pkg::ACC_WIDTH-1], scr_ff};
      num_pos = !num[cgd_pkg::ACC_WIDTH] && (num != '0);
      den_pos = !spq_ff[cgd_pkg::ACC_WIDTH-1] && (spq_ff != '0);
      fin_corr_last = (state_ff == S_FIN) && (func_ff == cgd_pkg::FUNC_CORR) && last_ff;
      div_start = fin_corr_last && !restart_ff && num_pos && den_pos;
   end

   cgd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (num[cgd_pkg::ACC_WIDTH-1:0]),
      .denom (spq_ff[cgd_pkg::DEN_WIDTH-1:0]),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in   = state_ff;
      sgs_in     = sgs_ff;
      scr_in     = scr_ff;
      spq_in     = spq_ff;
      beta_in    = beta_ff;
      res_dir_in = res_dir_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            if (func_ff == cgd_pkg::FUNC_CORR) begin
               sgs_in = acc_add(sgs_ff, gg_ff);
               scr_in = acc_add(scr_ff, gp_ff);
               spq_in = acc_add(spq_ff, pp_ff);
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            res_dir_in = (func_ff == cgd_pkg::FUNC_UPDATE) ? dir_new : '0;
            if ((func_ff == cgd_pkg::FUNC_CORR) && !last_ff) begin
               state_in = S_IDLE;
            end else if (div_start) begin
               state_in = S_DIV;
            end else begin
               state_in = S_EMIT;
            end
            if (fin_corr_last) begin
               sgs_in = '0;
               scr_in = '0;
               spq_in = '0;
               if (!div_start) begin
                  beta_in = '0;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               beta_in  = div_quot;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         restart_ff   <= 1'b1;
         sgs_ff       <= '0;
         scr_ff       <= '0;
         spq_ff       <= '0;
         beta_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sgs_ff   <= sgs_in;
         scr_ff   <= scr_in;
         spq_ff   <= spq_in;
         beta_ff  <= beta_in;
         if (csr_we) begin
            restart_ff <= csr_wdata;
         end
         if ((state_ff == S_EMIT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Both stores: read at accept, written back when the update item finishes.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         prev_mem[addr_wr] <= grad_ff;
         dir_mem[addr_wr]  <= dir_new;
      end
      if (accept) begin
         prev_rd_ff <= prev_mem[addr_rd];
         dir_rd_ff  <= dir_mem[addr_rd];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= cgd_pkg::func_type'(req_func);
         index_ff <= req_index;
         grad_ff  <= req_grad;
         last_ff  <= req_last;
      end
      if (state_ff == S_MUL) begin
         gg_ff   <= grad_ff * grad_ff;
         gp_ff   <= grad_ff * prev_rd_ff;
         pp_ff   <= prev_rd_ff * prev_rd_ff;
         pm_ff   <= pm_in;
         dneg_ff <= dir_rd_ff[cgd_pkg::GRAD_WIDTH-1];
      end
      if (state_ff == S_ADD) begin
         prod_ff <= prod_in;
      end
      res_dir_ff <= res_dir_in;
      if ((state_ff == S_EMIT) && out_free) begin
         rsp_kind_ff  <= (func_ff == cgd_pkg::FUNC_CORR) ? cgd_pkg::KIND_BETA
                                                         : cgd_pkg::KIND_DIRECTION;
         rsp_index_ff <= index_ff;
         rsp_dir_ff   <= res_dir_ff;
         rsp_beta_ff  <= ((func_ff == cgd_pkg::FUNC_UPDATE) && restart_ff) ? '0 : beta_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_direction = rsp_dir_ff;
   assign rsp_beta      = rsp_beta_ff;
   assign rsp_out_last  = rsp_last_ff;

   assign beta_shown   = rsp_valid && (rsp_kind == cgd_pkg::KIND_BETA);
   assign corr_mid_fin = (state_ff == S_FIN) && (func_ff == cgd_pkg::FUNC_CORR) && !last_ff;

   `CGD_ASSERT_NEXT(a_accept_starts_mul, clock, reset, accept, state_ff == S_MUL)
   `CGD_ASSERT_IMP(a_div_done_in_div, clock, reset, div_done, state_ff == S_DIV)
   `CGD_ASSERT_IMP(a_beta_report_form, clock, reset, beta_shown, rsp_out_last && (rsp_direction == '0))
   `CGD_ASSERT_NEXT(a_corr_mid_no_result, clock, reset, corr_mid_fin, state_ff == S_IDLE)

endmodule

// ----- sim/cgd_direction_checker.sv -----
// Result checker for conjugate_gradient_direction_top: watches the item, result and
// register ports, predicts every result and compares in order. Depends on cgd_pkg.
`timescale 1ns / 1ps

module cgd_direction_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [cgd_pkg::INDEX_WIDTH-1:0]        req_index,
   input  logic signed [cgd_pkg::GRAD_WIDTH-1:0]  req_grad,
   input  logic                                   req_last,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic                                   rsp_kind,
   input  logic [cgd_pkg::INDEX_WIDTH-1:0]        rsp_out_index,
   input  logic signed [cgd_pkg::GRAD_WIDTH-1:0]  rsp_direction,
   input  logic [cgd_pkg::BETA_WIDTH-1:0]         rsp_beta,
   input  logic                                   rsp_out_last,
   input  logic                                   csr_we,
   input  logic                                   csr_wdata,
   input  logic                                   wrap_up,
   output int                                     outstanding,
   output int                                     mismatch_count,
   output int                                     beta_checks,
   output int                                     direction_checks
);
   import cgd_pkg::*;

   localparam longint ACC_TOP    = (64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1;
   localparam longint ACC_BOTTOM = -ACC_TOP - 64'sd1;
   localparam longint DIR_TOP    = (64'sd1 <<< (GRAD_WIDTH - 1)) - 64'sd1;
   localparam longint DIR_BOTTOM = -DIR_TOP - 64'sd1;
   localparam logic [63:0] SCALE_CAP = 64'd1 << (GRAD_WIDTH + FRAC_BITS);
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      kind_type                      kind;
      logic [INDEX_WIDTH-1:0]        index;
      logic signed [GRAD_WIDTH-1:0]  direction;
      logic [BETA_WIDTH-1:0]         beta;
      logic                          last;
   } cgd_result_type;

   cgd_result_type pending_results[$];

   logic signed [GRAD_WIDTH-1:0] prev_grad_mem [VECTOR_DEPTH];
   logic signed [GRAD_WIDTH-1:0] dir_mem [VECTOR_DEPTH];
   longint sum_gg = 0;
   longint sum_gp = 0;
   longint sum_pp = 0;
   logic [BETA_WIDTH-1:0] held_beta = '0;
   bit restart_on = 1'b1;
   bit wrapped = 1'b0;
   int mismatches = 0;
   int results_seen = 0;
   int beta_total = 0;
   int direction_total = 0;

   function automatic longint accumulate(longint acc, longint term);
      longint total;
      total = acc + term;
      if (total > ACC_TOP) return ACC_TOP;
      if (total < ACC_BOTTOM) return ACC_BOTTOM;
      return total;
   endfunction

   // beta = (|g|^2 - g.p) / |p|^2, cut toward zero to Q16.16 and clamped to [0, max].
   function automatic logic [BETA_WIDTH-1:0] polak_ribiere_beta(longint gg, longint gp,
                                                                longint pp);
      longint num;
      logic [63:0] n, c, q, r, frac;
      int k;
      num = gg - gp;
      if (pp <= 0 || num <= 0) return '0;
      n = num;
      c = pp;
      q = n / c;
      if (q >= (64'd1 << BETA_INT_BITS)) return '1;
      r = n % c;
      frac = '0;
      for (k = 0; k < FRAC_BITS; k++) begin
         r = r << 1;
         frac = frac << 1;
         if (r >= c) begin
            r = r - c;
            frac = frac | 64'd1;
         end
      end
      return BETA_WIDTH'((q << FRAC_BITS) | frac);
   endfunction

   // d = g + beta * d_old, the product magnitude capped, rounded half up, then saturated.
   function automatic logic signed [GRAD_WIDTH-1:0] step_direction(
      logic signed [GRAD_WIDTH-1:0] grad,
      logic signed [GRAD_WIDTH-1:0] old_dir,
      logic [BETA_WIDTH-1:0]        beta);
      longint g, d, prod, total, res;
      logic [63:0] mag, scaled;
      g = grad;
      d = old_dir;
      mag = (d < 0) ? -d : d;
      scaled = mag * beta;
      if (scaled > SCALE_CAP) scaled = SCALE_CAP;
      prod = (d < 0) ? -longint'(scaled) : longint'(scaled);
      total = (g <<< FRAC_BITS) + prod + (64'sd1 <<< (FRAC_BITS - 1));
      res = total >>> FRAC_BITS;
      if (res > DIR_TOP) res = DIR_TOP;
      if (res < DIR_BOTTOM) res = DIR_BOTTOM;
      return GRAD_WIDTH'(res);
   endfunction

   // Every mismatch is counted; only the first few are printed to keep the log short.
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t: %s mismatch at result %0d: got 0x%0h, expected 0x%0h",
                  $time, what, results_seen, got, want);
   endtask

   always @(posedge clock) begin : watch
      logic [ADDR_WIDTH-1:0] addr;
      longint g, p;
      logic [BETA_WIDTH-1:0] beta_now;
      logic signed [GRAD_WIDTH-1:0] new_dir;
      cgd_result_type want;
      if (reset) begin
         pending_results.delete();
         sum_gg = 0;
         sum_gp = 0;
         sum_pp = 0;
         held_beta = '0;
         restart_on = 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result, index", 64'(rsp_out_index), '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", 64'(rsp_kind), 64'(want.kind));
               if (rsp_out_index !== want.index)
                  report_mismatch("index", 64'(rsp_out_index), 64'(want.index));
               if (rsp_direction !== want.direction)
                  report_mismatch("direction", 64'(rsp_direction), 64'(want.direction));
               if (rsp_beta !== want.beta)
                  report_mismatch("beta", 64'(rsp_beta), 64'(want.beta));
               if (rsp_out_last !== want.last)
                  report_mismatch("last", 64'(rsp_out_last), 64'(want.last));
               if (want.kind == KIND_BETA) beta_total++;
               else direction_total++;
            end
         end

         if (req_valid && !req_stall) begin
            addr = req_index[ADDR_WIDTH-1:0];
            g = req_grad;
            if (req_func == FUNC_CORR) begin
               p = prev_grad_mem[addr];
               sum_gg = accumulate(sum_gg, g * g);
               sum_gp = accumulate(sum_gp, g * p);
               sum_pp = accumulate(sum_pp, p * p);
               if (req_last) begin
                  held_beta = restart_on ? '0 : polak_ribiere_beta(sum_gg, sum_gp, sum_pp);
                  sum_gg = 0;
                  sum_gp = 0;
                  sum_pp = 0;
                  pending_results.push_back('{KIND_BETA, req_index, '0, held_beta, 1'b1});
               end
            end else begin
               beta_now = restart_on ? '0 : held_beta;
               new_dir = restart_on ? req_grad
                                    : step_direction(req_grad, dir_mem[addr], beta_now);
               dir_mem[addr] = new_dir;
               prev_grad_mem[addr] = req_grad;
               pending_results.push_back('{KIND_DIRECTION, req_index, new_dir, beta_now,
                                           req_last});
            end
         end

         if (csr_we) restart_on = csr_wdata;

         if (wrap_up && !wrapped) begin
            wrapped = 1'b1;
            foreach (pending_results[i])
               report_mismatch("missing result, index", '0, 64'(pending_results[i].index));
         end
      end
      outstanding <= pending_results.size();
      mismatch_count <= mismatches;
      beta_checks <= beta_total;
      direction_checks <= direction_total;
   end

endmodule

// ----- sim/conjugate_gradient_direction_top_test.sv -----
// Testbench top for conjugate_gradient_direction_top: clock, reset, item stimulus,
// receiver stalls and the verdict. Depends on cgd_pkg, the block and cgd_direction_checker.
`timescale 1ns / 1ps

module conjugate_gradient_direction_top_test;
   import cgd_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int SETTLE_CYCLES = 60;
   localparam logic signed [GRAD_WIDTH-1:0] GRAD_TOP    = {1'b0, {(GRAD_WIDTH-1){1'b1}}};
   localparam logic signed [GRAD_WIDTH-1:0] GRAD_BOTTOM = {1'b1, {(GRAD_WIDTH-1){1'b0}}};
   localparam logic [INDEX_WIDTH-1:0] INDEX_TOP = '1;

   typedef enum int {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE, STALL_HOLD
   } stall_mode_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_func;
   logic [INDEX_WIDTH-1:0] req_index;
   logic signed [GRAD_WIDTH-1:0] req_grad;
   logic req_last;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_kind;
   logic [INDEX_WIDTH-1:0] rsp_out_index;
   logic signed [GRAD_WIDTH-1:0] rsp_direction;
   logic [BETA_WIDTH-1:0] rsp_beta;
   logic rsp_out_last;
   logic csr_we;
   logic csr_wdata;
   logic wrap_up;

   int outstanding;
   int mismatch_count;
   int beta_checks;
   int direction_checks;

   int cycle_count = 0;
   int items_sent = 0;
   int settings_used = 0;
   int burst_left = 0;
   bit seeded [VECTOR_DEPTH];
   index_type seeded_list[$];

   conjugate_gradient_direction_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_index     (req_index),
      .req_grad      (req_grad),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_out_index (rsp_out_index),
      .rsp_direction (rsp_direction),
      .rsp_beta      (rsp_beta),
      .rsp_out_last  (rsp_out_last),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata)
   );

   cgd_direction_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_index        (req_index),
      .req_grad         (req_grad),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_index    (rsp_out_index),
      .rsp_direction    (rsp_direction),
      .rsp_beta         (rsp_beta),
      .rsp_out_last     (rsp_out_last),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .wrap_up          (wrap_up),
      .outstanding      (outstanding),
      .mismatch_count   (mismatch_count),
      .beta_checks      (beta_checks),
      .direction_checks (direction_checks)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles without finishing.", cycle_count);
      $display("== FAIL ==");
      $finish;
   end

   // The receiver stalls in segments of its own choosing. A long hold while items are
   // still coming lets the output fill up so that the block has to stall its input.
   initial begin : receiver_stall
      stall_mode_type mode;
      int span;
      int pick;
      bit held_once;
      rsp_stall <= 1'b0;
      held_once = 1'b0;
      forever begin
         pick = $urandom_range(0, 19);
         if ((!held_once && cycle_count > 2000 && req_valid) || pick == 0) mode = STALL_HOLD;
         else if (pick <= 6) mode = STALL_NONE;
         else if (pick <= 12) mode = STALL_LIGHT;
         else if (pick <= 16) mode = STALL_HEAVY;
         else mode = STALL_TOGGLE;
         if (mode == STALL_HOLD) held_once = 1'b1;
         span = (mode == STALL_HOLD) ? $urandom_range(300, 600) : $urandom_range(20, 200);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
               STALL_TOGGLE: rsp_stall <= ~rsp_stall;
               default:      rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   // Items go out in bursts, and valid drops only between bursts.
   task automatic send_item(func_type f, index_type idx, logic signed [GRAD_WIDTH-1:0] g,
                            logic l);
      if (burst_left == 0) begin
         repeat (($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 2))
            @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_index <= idx;
      req_grad <= g;
      req_last <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      // An update item writes both stores, so the entry may be read from now on.
      if (f == FUNC_UPDATE && !seeded[idx]) begin
         seeded[idx] = 1'b1;
         seeded_list.push_back(idx);
      end
      burst_left--;
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   task automatic stop_sending();
      if (burst_left != 0) begin
         req_valid <= 1'b0;
         burst_left = 0;
      end
   endtask

   // The register is only written once every result is back and the block has settled.
   task automatic set_restart(bit value);
      stop_sending();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic index_type pick_seeded();
      return seeded_list[$urandom_range(0, seeded_list.size() - 1)];
   endfunction

   function automatic logic signed [GRAD_WIDTH-1:0] pick_grad();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return GRAD_TOP;
               1: return GRAD_BOTTOM;
               2: return '0;
               default: return '1;
            endcase
         end
         1, 2: return GRAD_WIDTH'($urandom_range(0, 4096)) - GRAD_WIDTH'(2048);
         default: return GRAD_WIDTH'($urandom);
      endcase
   endfunction

   task automatic run_pass(func_type f, index_type vec[$]);
      foreach (vec[i]) send_item(f, vec[i], pick_grad(), i == vec.size() - 1);
   endtask

   // One iteration of the method: correlation pass, then direction pass over the same
   // elements. With restart on, fresh elements are written first by a direction pass.
   task automatic run_iteration(bit restart_mode);
      index_type vec[$];
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
      repeat (len) begin
         if (restart_mode && $urandom_range(0, 1)) vec.push_back(index_type'($urandom));
         else vec.push_back(pick_seeded());
      end
      if (restart_mode) run_pass(FUNC_UPDATE, vec);
      run_pass(FUNC_CORR, vec);
      run_pass(FUNC_UPDATE, vec);
   endtask

   task automatic send_noise(bit restart_mode);
      func_type f;
      index_type idx;
      f = func_type'($urandom_range(0, 1));
      if (f == FUNC_UPDATE && restart_mode && $urandom_range(0, 1))
         idx = index_type'($urandom);
      else idx = pick_seeded();
      send_item(f, idx, pick_grad(), $urandom_range(0, 1));
   endtask

   initial begin : stimulus
      int random_start;
      int iterations;
      bit restart_mode;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_CORR;
      req_index <= '0;
      req_grad <= '0;
      req_last <= 1'b0;
      csr_we <= 1'b0;
      csr_wdata <= 1'b0;
      wrap_up <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Restart is on out of reset: the direction equals the gradient and beta reads zero.
      send_item(FUNC_UPDATE, '0, GRAD_TOP, 1'b0);
      send_item(FUNC_UPDATE, INDEX_TOP, GRAD_BOTTOM, 1'b0);
      send_item(FUNC_UPDATE, index_type'(1), '0, 1'b0);
      send_item(FUNC_UPDATE, index_type'(2), 24'sd1, 1'b0);
      send_item(FUNC_UPDATE, index_type'(3), 24'sd4, 1'b1);
      send_item(FUNC_CORR, '0, 24'sd5, 1'b0);
      send_item(FUNC_CORR, index_type'(3), 24'sd1, 1'b1);

      set_restart(1'b0);
      // Zero divisor, then a negative numerator, then a beta past its range.
      send_item(FUNC_CORR, index_type'(1), 24'sd100, 1'b1);
      send_item(FUNC_CORR, index_type'(3), 24'sd1, 1'b1);
      send_item(FUNC_CORR, index_type'(2), GRAD_TOP, 1'b1);
      // With the largest beta the directions saturate at both ends.
      send_item(FUNC_UPDATE, '0, GRAD_TOP, 1'b0);
      send_item(FUNC_UPDATE, INDEX_TOP, GRAD_BOTTOM, 1'b0);
      send_item(FUNC_UPDATE, index_type'(2), '1, 1'b1);
      send_item(FUNC_CORR, '0, 24'sd4194304, 1'b0);
      send_item(FUNC_CORR, INDEX_TOP, -24'sd1000, 1'b1);
      send_item(FUNC_UPDATE, '0, 24'sd12345, 1'b0);
      send_item(FUNC_UPDATE, INDEX_TOP, -24'sd54321, 1'b1);

      random_start = items_sent;
      restart_mode = 1'b1;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         set_restart(restart_mode);
         iterations = $urandom_range(1, 4);
         repeat (iterations) begin
            run_iteration(restart_mode);
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 6)) send_noise(restart_mode);
         end
         restart_mode = ($urandom_range(0, 4) == 0);
      end

      stop_sending();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      wrap_up <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d items under %0d restart settings, %0d elements in use.",
               items_sent, settings_used, seeded_list.size());
      $display("Compared %0d direction elements and %0d beta reports.",
               direction_checks, beta_checks);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
